### rtl/iit_pkg.sv
// ----------------------------------------------------------------------------
// iit_pkg
// Shared types and constants for the id interning table.
// ----------------------------------------------------------------------------
package iit_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int REM_W       = 8;
  localparam int REM_COUNT   = 3;
  localparam int ID_W        = 16;

  localparam logic [REM_W-1:0] SLOT_INVALID = 8'hff;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [1:0] TIX_PLAIN = 2'd0;

  typedef struct packed {
    logic                   operation;
    logic signed [ID_W-1:0] id_key;
    logic [1:0]             translation_index;
  } request_t;

  typedef struct packed {
    logic [5:0] slot_index;
    logic       is_null;
    logic       newly_allocated;
    logic       overflow;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic clear;
    logic null_res;
    logic scan_init;
    logic scan_step;
    logic rem_read;
    logic found;
    logic append;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_clear;
    logic id_zero;
    logic tix_plain;
    logic rem_ok;
    logic table_empty;
    logic hit;
    logic scan_end;
  } status_t;

endpackage

### rtl/iit_datapath.sv
// ----------------------------------------------------------------------------
// iit_datapath
// Slot store, fill count, remembered slots, compare and result register.
// ----------------------------------------------------------------------------
module iit_datapath
  import iit_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  request_t request,
  input  cmd_t     cmd,
  output status_t  status,
  output result_t  result,
  output logic     done
);

  logic [ID_W-1:0]    slot_ids [TABLE_SLOTS];
  logic [ID_W-1:0]    rd_data;
  logic [SLOT_W-1:0]  rd_addr;
  logic [COUNT_W-1:0] used_count;
  logic [REM_W-1:0]   rem_slots [REM_COUNT];
  logic [COUNT_W-1:0] scan_idx;
  logic [SLOT_W-1:0]  cmp_idx;
  request_t           req_q;
  logic [1:0]         rem_sel_idx;
  logic [REM_W-1:0]   rem_sel;
  logic               full;
  result_t            result_next;

  assign rem_sel_idx = req_q.translation_index - 2'd1;
  assign rem_sel     = rem_slots[rem_sel_idx];
  assign full        = (used_count == COUNT_W'(TABLE_SLOTS));

  assign status.op_clear    = (req_q.operation == OP_CLEAR);
  assign status.id_zero     = (req_q.id_key == '0);
  assign status.tix_plain   = (req_q.translation_index == TIX_PLAIN);
  assign status.rem_ok      = (rem_sel < REM_W'(used_count));
  assign status.table_empty = (used_count == '0);
  assign status.hit         = (rd_data == req_q.id_key);
  assign status.scan_end    = (scan_idx == used_count);

  always_comb begin
    if (cmd.rem_read) begin
      rd_addr = rem_sel[SLOT_W-1:0];
    end else if (cmd.scan_step) begin
      rd_addr = scan_idx[SLOT_W-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  // slot store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    rd_data <= slot_ids[rd_addr];
    if (cmd.append && !full) begin
      slot_ids[used_count[SLOT_W-1:0]] <= req_q.id_key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= request;
    end
    if (cmd.scan_init) begin
      scan_idx <= COUNT_W'(1);
      cmp_idx  <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + COUNT_W'(1);
      cmp_idx  <= scan_idx[SLOT_W-1:0];
    end else if (cmd.rem_read) begin
      cmp_idx  <= rem_sel[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      for (int i = 0; i < REM_COUNT; i++) begin
        rem_slots[i] <= SLOT_INVALID;
      end
    end else if (cmd.clear) begin
      used_count <= '0;
      for (int i = 0; i < REM_COUNT; i++) begin
        rem_slots[i] <= SLOT_INVALID;
      end
    end else if (cmd.append) begin
      if (full) begin
        if (!status.tix_plain) begin
          rem_slots[rem_sel_idx] <= SLOT_INVALID;
        end
      end else begin
        used_count <= used_count + COUNT_W'(1);
        if (!status.tix_plain) begin
          rem_slots[rem_sel_idx] <= REM_W'(used_count);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.clear | cmd.null_res | cmd.found | cmd.append;
    end
  end

  always_comb begin
    result_next = '0;
    if (cmd.null_res) begin
      result_next.is_null = 1'b1;
    end else if (cmd.found) begin
      result_next.slot_index = 6'(cmp_idx);
    end else if (cmd.append) begin
      if (full) begin
        result_next.overflow = 1'b1;
      end else begin
        result_next.slot_index      = 6'(used_count);
        result_next.newly_allocated = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

### rtl/iit_ctrl.sv
// ----------------------------------------------------------------------------
// iit_ctrl
// Sequencer for decode, slot scan, remembered-slot check and append.
// ----------------------------------------------------------------------------
module iit_ctrl
  import iit_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RCHK,
    S_APPEND
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.op_clear) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else if (status.id_zero) begin
          cmd.null_res = 1'b1;
          state_next   = S_IDLE;
        end else if (status.tix_plain) begin
          if (status.table_empty) begin
            state_next = S_APPEND;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end else if (status.rem_ok) begin
          cmd.rem_read = 1'b1;
          state_next   = S_RCHK;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_SCAN: begin
        // compare the slot read last cycle while reading the next one
        if (status.hit) begin
          cmd.found  = 1'b1;
          state_next = S_IDLE;
        end else if (status.scan_end) begin
          state_next = S_APPEND;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RCHK: begin
        if (status.hit) begin
          cmd.found  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/id_interning_table_top.sv
// throughput: busy drops in the cycle done is shown, so a new transfer may start then;
// the scan reads one slot per cycle through the single read port of the slot store.
// reset: synchronous, empties the table and invalidates remembered slots;
// results are never stalled, done is a one-cycle strobe.
// ----------------------------------------------------------------------------
// id_interning_table_top
// Find-or-insert table of signed 16-bit ids with three remembered slots.
// ----------------------------------------------------------------------------
module id_interning_table_top
  import iit_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  cmd_t    cmd;
  status_t status;

  iit_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  iit_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .result  (result),
    .done    (done)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> $countones({result.is_null, result.newly_allocated, result.overflow}) <= 1)
    else $error("more than one result flag set");

  a_no_slot_flag: assert property (@(posedge clk) disable iff (rst)
    done && (result.is_null || result.overflow) |-> result.slot_index == '0)
    else $error("slot index given with null or overflow result");
`endif

endmodule

### tb/id_interning_table_top_tb.sv
// ----------------------------------------------------------------------------
// id_interning_table_top_tb
// Self-checking bench for the id interning table: requests go in through the
// start/busy command port, and every done strobe is compared with the
// result that a behavioral copy of the table predicted when the request was
// taken.
// ----------------------------------------------------------------------------
module id_interning_table_top_tb;
  import iit_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic     clk;
  logic     rst;
  logic     start;
  request_t request;
  logic     busy;
  logic     done;
  result_t  result;

  // behavioral copy of the table
  logic [ID_W-1:0]  interned_ids [TABLE_SLOTS];
  int unsigned      interned_count;
  logic [REM_W-1:0] pinned_slots [REM_COUNT];

  result_t     pending_results [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned items_sent;
  bit          steady;

  id_interning_table_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void empty_table();
    interned_count = 0;
    for (int i = 0; i < REM_COUNT; i++) pinned_slots[i] = SLOT_INVALID;
  endfunction

  function automatic result_t append_id(logic [ID_W-1:0] key);
    result_t res;
    res = '0;
    if (interned_count >= TABLE_SLOTS) begin
      res.overflow = 1'b1;
    end else begin
      interned_ids[interned_count] = key;
      res.slot_index      = 6'(interned_count);
      res.newly_allocated = 1'b1;
      interned_count++;
    end
    return res;
  endfunction

  function automatic result_t intern_id(request_t r);
    result_t          res;
    logic [REM_W-1:0] pin;
    int               hit;
    int unsigned      ix;
    res = '0;
    hit = -1;
    if (r.operation == OP_CLEAR) begin
      empty_table();
    end else if (r.id_key == 0) begin
      res.is_null = 1'b1;
    end else if (r.translation_index == TIX_PLAIN) begin
      for (int i = 0; i < interned_count; i++) begin
        if (hit < 0 && interned_ids[i] == r.id_key) hit = i;
      end
      if (hit >= 0) res.slot_index = 6'(hit);
      else res = append_id(r.id_key);
    end else begin
      ix  = r.translation_index - 1;
      pin = pinned_slots[ix];
      if (pin < interned_count && interned_ids[pin] == r.id_key) begin
        res.slot_index = 6'(pin);
      end else begin
        res = append_id(r.id_key);
        pinned_slots[ix] = res.overflow ? SLOT_INVALID : REM_W'(interned_count - 1);
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing expected, actual %p", $time, got);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("slot_index", want.slot_index, got.slot_index);
      check_field("is_null", want.is_null, got.is_null);
      check_field("newly_allocated", want.newly_allocated, got.newly_allocated);
      check_field("overflow", want.overflow, got.overflow);
    end
  endtask

  // results are checked before the transfer of the same edge is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (done) check_result(result);
      if (start && !busy) pending_results.push_back(intern_id(request));
    end
  end

  task automatic send_item(logic op, logic [ID_W-1:0] key, logic [1:0] tix);
    request_t r;
    int unsigned gap;
    r.operation         = op;
    r.id_key            = key;
    r.translation_index = tix;
    if (!steady && $urandom_range(99) < 19) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
    items_sent++;
  endtask

  task automatic lookup(logic [ID_W-1:0] key, logic [1:0] tix);
    send_item(OP_LOOKUP, key, tix);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] nonzero_id();
    logic [ID_W-1:0] key;
    key = ID_W'($urandom);
    if (key == 0) key = 16'h0001;
    return key;
  endfunction

  task automatic test_directed_cases();
    lookup(16'h0000, 2'd0);
    lookup(16'h0000, 2'd3);
    lookup(16'h0001, TIX_PLAIN);
    lookup(16'h0001, TIX_PLAIN);
    lookup(16'h7fff, TIX_PLAIN);
    lookup(16'h8000, TIX_PLAIN);
    lookup(16'hffff, TIX_PLAIN);
    // pinned lookup appends even though the id already has a slot
    lookup(16'h0001, 2'd1);
    lookup(16'h0001, 2'd1);
    lookup(16'h7fff, 2'd1);
    lookup(16'h8000, 2'd2);
    lookup(16'h5555, 2'd3);
    lookup(16'h5555, 2'd3);
    lookup(16'h5555, TIX_PLAIN);
    lookup(16'h7fff, TIX_PLAIN);
    send_item(OP_CLEAR, 16'haaaa, 2'd3);
    // pins are invalid after a clear
    lookup(16'h8000, 2'd2);
    lookup(16'h8000, 2'd2);
    lookup(16'h8000, TIX_PLAIN);
    send_item(OP_CLEAR, 16'h0000, 2'd0);
    send_item(OP_CLEAR, 16'hffff, 2'd1);
    lookup(16'h0000, 2'd1);
    lookup(16'h1234, 2'd2);
    wait_drained();
  endtask

  task automatic test_table_full();
    send_item(OP_CLEAR, 16'h0000, 2'd0);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (i == 10) lookup(16'h4000, 2'd1);
      else lookup(ID_W'(16'h0100 + i), TIX_PLAIN);
    end
    lookup(16'h2222, TIX_PLAIN);
    lookup(16'h3333, 2'd2);
    lookup(16'h4000, 2'd1);
    lookup(16'h2222, 2'd1);
    // pin 1 was dropped by the overflow, so this misses as well
    lookup(16'h4000, 2'd1);
    lookup(16'h013f, TIX_PLAIN);
    lookup(16'h4000, TIX_PLAIN);
    lookup(16'h0000, 2'd1);
    send_item(OP_CLEAR, 16'h7777, 2'd2);
    lookup(16'h4000, 2'd1);
    wait_drained();
  endtask

  task automatic run_frames(int unsigned budget);
    logic [ID_W-1:0] pool [6];
    int unsigned     frame_len;
    int unsigned     random_pct;
    int unsigned     pick;
    int unsigned     sent;
    logic [ID_W-1:0] key;
    sent = 0;
    while (sent < budget) begin
      send_item(OP_CLEAR, ID_W'($urandom), 2'($urandom));
      sent++;
      if ($urandom_range(8) == 0) begin
        frame_len  = $urandom_range(60, 90);
        random_pct = 60;
      end else begin
        frame_len  = $urandom_range(4, 30);
        random_pct = 22;
      end
      foreach (pool[i]) begin
        case ($urandom_range(5))
          0: pool[i] = 16'h8000;
          1: pool[i] = 16'h7fff;
          default: pool[i] = nonzero_id();
        endcase
      end
      for (int n = 0; n < frame_len && sent < budget; n++) begin
        pick = $urandom_range(99);
        if (pick < 5) key = '0;
        else if (pick < 5 + random_pct) key = ID_W'($urandom);
        else key = pool[$urandom_range(5)];
        if ($urandom_range(49) == 0) send_item(OP_CLEAR, key, 2'($urandom));
        else lookup(key, 2'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random_frames();
    run_frames(480);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    run_frames(80);
    steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    error_count    = 0;
    cycle_count    = 0;
    items_sent     = 0;
    steady         = 1'b0;
    empty_table();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_table_full();
    test_random_frames();
    test_back_to_back();

    wait_drained();
    repeat (80) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
